// File: hdl/u16u8_pkg.sv
// shared types, constants and utf-8 encoding helpers for the utf-16 to utf-8 transcoder
// no dependencies
package u16u8_pkg;

  localparam int CP_W        = 21;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [5:0]      HIGH_TAG  = 6'b110110;
  localparam logic [5:0]      LOW_TAG   = 6'b110111;
  localparam logic [CP_W-1:0] REPL_CP   = 21'h00FFFD;
  localparam logic [CP_W-1:0] SUPP_BASE = 21'h010000;
  localparam logic [2:0]      REPL_LEN  = 3'd3;

  // one unit of work for the byte serializer
  typedef struct packed {
    logic            pre_rep;  // a replacement for a dropped high surrogate comes first
    logic            has_cp;   // a code point follows
    logic            cp_rep;   // that code point is itself a replacement
    logic            last;     // the unit ended the string
    logic [CP_W-1:0] cp;
  } u16u8_job_t;

  function automatic logic [2:0] utf8_len(input logic [CP_W-1:0] cp);
    logic [2:0] len;
    if (cp <= 21'h00007F) begin
      len = 3'd1;
    end else if (cp <= 21'h0007FF) begin
      len = 3'd2;
    end else if (cp <= 21'h00FFFF) begin
      len = 3'd3;
    end else begin
      len = 3'd4;
    end
    return len;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp, input logic [1:0] k);
    logic [2:0] len;
    logic [7:0] b;
    len = utf8_len(cp);
    b   = 8'h00;
    case (len)
      3'd1: b = {1'b0, cp[6:0]};
      3'd2: begin
        case (k)
          2'd0:    b = {3'b110, cp[10:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      3'd3: begin
        case (k)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        case (k)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

// File: hdl/utf16_to_utf8_transcoder.sv
// top level of the utf-16 to utf-8 transcoder: front end, job queue and byte serializer
// depends on u16u8_pkg, u16u8_front, u16u8_queue and u16u8_back
//
// Takes one UTF-16 code unit per item (in_tdata, in_tlast marks the last unit of a
// string) and gives UTF-8 one byte per item. A surrogate pair gives four bytes on the
// low unit; an unpaired or string-final high surrogate and a lone low surrogate each
// give U+FFFD (EF BF BD) with the replaced flag set, so one unit gives zero to six
// bytes. The output serializer sends one byte per cycle while out_tready is high. A
// four-entry job queue lets units enter while earlier ones are still being serialized;
// a unit's first byte passes through the job queue, the job register and the output
// register.
module utf16_to_utf8_transcoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] code_unit
  input  logic        in_tlast,   // last_unit
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast,  // string_end
  output logic [1:0]  out_tuser   // [0] run_end, [1] replaced
);
  import u16u8_pkg::*;

  u16u8_job_t push_job, head_job;
  logic       push, queue_full, job_avail, pop;
  logic       run_end, replaced;

  u16u8_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .code_unit  (in_tdata),
    .last_unit  (in_tlast),
    .queue_full (queue_full),
    .push       (push),
    .job        (push_job)
  );

  u16u8_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (job_avail),
    .head_job  (head_job)
  );

  u16u8_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_avail  (job_avail),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_tdata),
    .run_end    (run_end),
    .string_end (out_tlast),
    .replaced   (replaced)
  );

  assign out_tuser = {replaced, run_end};

endmodule

// File: hdl/u16u8_front.sv
// front end: accepts utf-16 units, pairs surrogates and emits jobs for the serializer
// depends on u16u8_pkg
module u16u8_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [15:0]           code_unit,
  input  logic                  last_unit,
  input  logic                  queue_full,
  output logic                  push,
  output u16u8_pkg::u16u8_job_t job
);
  import u16u8_pkg::*;

  logic [9:0] held_high_bits_r, held_high_bits_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic       is_high, is_low, accept;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign is_high  = (code_unit[15:10] == HIGH_TAG);
  assign is_low   = (code_unit[15:10] == LOW_TAG);

  always_comb begin
    held_high_bits_nxt = held_high_bits_r;
    held_valid_nxt     = held_valid_r;
    job.pre_rep        = held_valid_r && !is_low;
    job.has_cp         = 1'b1;
    job.cp_rep         = 1'b0;
    job.last           = last_unit;
    job.cp             = {5'd0, code_unit};
    if (held_valid_r && is_low) begin
      job.cp = SUPP_BASE + {1'b0, held_high_bits_r, code_unit[9:0]};
    end else if (is_high) begin
      if (last_unit) begin
        job.cp     = REPL_CP;
        job.cp_rep = 1'b1;
      end else begin
        job.has_cp = 1'b0;
      end
    end else if (is_low) begin
      job.cp     = REPL_CP;
      job.cp_rep = 1'b1;
    end
    if (accept) begin
      held_valid_nxt     = is_high && !last_unit && !(held_valid_r && is_low);
      held_high_bits_nxt = held_valid_nxt ? code_unit[9:0] : 10'd0;
    end
  end

  assign push = accept && (job.pre_rep || job.has_cp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r     <= 1'b0;
      held_high_bits_r <= 10'd0;
    end else begin
      held_valid_r     <= held_valid_nxt;
      held_high_bits_r <= held_high_bits_nxt;
    end
  end

endmodule

// File: hdl/u16u8_queue.sv
// short job queue between the front end and the byte serializer
// depends on u16u8_pkg
module u16u8_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  u16u8_pkg::u16u8_job_t push_job,
  output logic                  full,
  input  logic                  pop,
  output logic                  not_empty,
  output u16u8_pkg::u16u8_job_t head_job
);
  import u16u8_pkg::*;

  u16u8_job_t          mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_CW-1:0] count_r;
  logic                do_push, do_pop;

  assign full      = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_job  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QUEUE_AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QUEUE_CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QUEUE_CW'(1);
      end
    end
  end

endmodule

// File: hdl/u16u8_back.sv
// back end: turns one job into utf-8 bytes, one per cycle while the output is not stalled, through an output register
// depends on u16u8_pkg
module u16u8_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  job_avail,
  input  u16u8_pkg::u16u8_job_t head_job,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  run_end,
  output logic                  string_end,
  output logic                  replaced
);
  import u16u8_pkg::*;

  u16u8_job_t job_r;
  logic       job_valid_r;
  logic [2:0] idx_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       run_end_r, string_end_r, replaced_r;

  logic [2:0] pre_cnt, main_cnt, total;
  logic       in_pre, last_byte, emit;
  logic [2:0] main_idx;
  logic [7:0] byte_nxt;
  logic       rep_nxt;

  always_comb begin
    pre_cnt   = job_r.pre_rep ? REPL_LEN : 3'd0;
    main_cnt  = job_r.has_cp ? utf8_len(job_r.cp) : 3'd0;
    total     = pre_cnt + main_cnt;
    in_pre    = job_r.pre_rep && (idx_r < REPL_LEN);
    main_idx  = idx_r - pre_cnt;
    last_byte = (idx_r == total - 3'd1);
    if (in_pre) begin
      byte_nxt = utf8_byte(REPL_CP, idx_r[1:0]);
      rep_nxt  = 1'b1;
    end else begin
      byte_nxt = utf8_byte(job_r.cp, main_idx[1:0]);
      rep_nxt  = job_r.cp_rep;
    end
  end

  // a byte of the loaded job moves into the output register whenever it is free or being drained
  assign emit = job_valid_r && (!out_valid_r || out_ready);
  assign pop  = !job_valid_r || (emit && last_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        job_valid_r <= job_avail;
        idx_r       <= 3'd0;
      end else if (emit) begin
        idx_r <= idx_r + 3'd1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && job_avail) begin
      job_r <= head_job;
    end
    if (emit) begin
      out_byte_r   <= byte_nxt;
      run_end_r    <= last_byte;
      string_end_r <= last_byte && job_r.last;
      replaced_r   <= rep_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign run_end    = run_end_r;
  assign string_end = string_end_r;
  assign replaced   = replaced_r;

endmodule

// File: hdl/u16u8_checker.sv
// port-level checks for the utf-16 to utf-8 transcoder, bound to the top level
// depends on utf16_to_utf8_transcoder
module u16u8_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast,
  input logic [1:0]  out_tuser
);

  // a stalled output byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output item changed while stalled");

  // string end always closes a run
  a_last_is_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[0])
    else $error("string end without run end");

  // replacement bytes are only those of U+FFFD
  a_repl_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |->
      (out_tdata == 8'hEF) || (out_tdata == 8'hBF) || (out_tdata == 8'hBD))
    else $error("replacement flag on a byte outside U+FFFD");

  // reset empties the output
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind utf16_to_utf8_transcoder u16u8_checker u_chk (.*);
